>>> design/pcm_sample_player_dac_macros.svh
// ----------------------------------------------------------------------------
// pcm sample player assertion macros
// shared property wrappers for the port-level checker
// ----------------------------------------------------------------------------
`ifndef PCM_SAMPLE_PLAYER_DAC_MACROS_SVH
`define PCM_SAMPLE_PLAYER_DAC_MACROS_SVH

// same-cycle implication, off during reset
`define PSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psp assertion failed");

// next-cycle implication, off during reset
`define PSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psp assertion failed");

`endif

>>> design/psp_pkg.sv
// ----------------------------------------------------------------------------
// psp_pkg
// widths, opcodes, register indexes and reset values of the pcm sample player
// ----------------------------------------------------------------------------
package psp_pkg;

  localparam int OP_W    = 2;
  localparam int LADDR_W = 16;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 17;
  localparam int FREQ_W  = 20;
  localparam int RATE_W  = 18;
  localparam int VOL_W   = 16;
  localparam int POS_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int STEP_W  = 32;
  localparam int CARRY_W = STEP_W - FRAC_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = RATE_W;

  // numerator of the step division: freq * 65536 + rate / 2
  localparam int NUM_W     = FREQ_W + FRAC_W + 1;
  localparam int DIV_STEPS = NUM_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // (raw - 128) * volume, signed
  localparam int PROD_W = 25;

  localparam int STORE_DEPTH_DEF = 65536;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_START   = 2'd1;
  localparam logic [OP_W-1:0] OP_SETFREQ = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME      = 1'd1;

  localparam logic [RATE_W-1:0] RATE_RST  = 18'd44100;
  localparam logic [VOL_W-1:0]  VOL_UNITY = 16'h0100;
  localparam logic [FREQ_W-1:0] FREQ_RST  = 20'd16000;
  localparam logic [BYTE_W-1:0] SILENCE   = 8'h80;

endpackage

>>> design/pcm_sample_player_dac.sv
// ----------------------------------------------------------------------------
// pcm_sample_player_dac
// 8-bit pcm player: sample store, 16.16 phase accumulator, volume scaling
//
// input channel (in_valid / in_stall) takes load, start, set-frequency and
// tick transfers; the result channel (out_valid / out_stall) gives one dac
// byte per tick whose phase carries while playing, with finished set on the
// silence byte that ends playback. in_stall is high while an item is in work.
// loads and ticks without carry stay in the idle state; loads stream one per
// cycle while in_stall is low. start and set-frequency run the step division
// on one shared restoring divider, one quotient bit per cycle; a zero output
// rate skips it and clears the step. a carrying tick runs add, position compare
// with store read, multiply, round and clamp, and output register load; one that
// ends playback skips multiply and round and clamp. the result sits in an
// output register, so a new item is accepted while it waits; a further result
// holds in its last stage until the output register is free. reset (rst_n,
// synchronous) stops playback and restores the registers; the sample store is
// not cleared and needs no pass. STORE_DEPTH must be a power of two (unchecked).
// ----------------------------------------------------------------------------
module pcm_sample_player_dac #(
  parameter int STORE_DEPTH = psp_pkg::STORE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [psp_pkg::OP_W-1:0]        in_operation,
  input  logic [psp_pkg::LADDR_W-1:0]     in_load_address,
  input  logic [psp_pkg::BYTE_W-1:0]      in_load_byte,
  input  logic [psp_pkg::LEN_W-1:0]       in_length,
  input  logic [psp_pkg::FREQ_W-1:0]      in_sample_freq,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [psp_pkg::BYTE_W-1:0]      out_dac_byte,
  output logic                            out_finished,
  input  logic                            cfg_we,
  input  logic [psp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(STORE_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_POS   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]                     state_r, state_nxt;
  logic                           playing_r, playing_nxt;
  logic [psp_pkg::LEN_W-1:0]      count_r, count_nxt;
  logic [psp_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [psp_pkg::FRAC_W-1:0]     frac_r, frac_nxt;
  logic [psp_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [psp_pkg::FREQ_W-1:0]     freq_r, freq_nxt;
  logic [psp_pkg::RATE_W-1:0]     rate_r, rate_nxt;
  logic [psp_pkg::VOL_W-1:0]      vol_r, vol_nxt;
  logic [psp_pkg::RATE_W-1:0]     div_r, div_nxt;
  logic [psp_pkg::NUM_W-1:0]      nq_r, nq_nxt;
  logic [psp_pkg::RATE_W-1:0]     rem_r, rem_nxt;
  logic [psp_pkg::DCNT_W-1:0]     cnt_r, cnt_nxt;
  logic [psp_pkg::CARRY_W-1:0]    carry_r, carry_nxt;
  logic signed [psp_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [psp_pkg::BYTE_W-1:0]     res_byte_r, res_byte_nxt;
  logic                           res_fin_r, res_fin_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [psp_pkg::BYTE_W-1:0]     out_byte_r, out_byte_nxt;
  logic                           out_fin_r, out_fin_nxt;

  logic [psp_pkg::BYTE_W-1:0]     rd_r;
  logic [psp_pkg::BYTE_W-1:0]     store_mem [STORE_DEPTH];

  logic                           mem_we, mem_re;
  logic [AW-1:0]                  wr_addr, rd_addr;
  logic [AW+psp_pkg::LADDR_W-1:0] laddr_ext;

  logic [psp_pkg::FREQ_W-1:0]     freq_sel;
  logic                           start_div;
  logic [psp_pkg::STEP_W:0]       acc;
  logic [psp_pkg::POS_W:0]        pos_sum;
  logic [psp_pkg::RATE_W:0]       trial, diff;
  logic                           qbit;
  logic [psp_pkg::NUM_W-1:0]      quot;
  logic signed [psp_pkg::BYTE_W:0] smp;
  logic signed [psp_pkg::PROD_W:0] prod_full;
  logic signed [psp_pkg::PROD_W-1:0] vsum;
  logic signed [psp_pkg::PROD_W-9:0] shifted;
  logic                           out_free;

  assign laddr_ext = {{AW{1'b0}}, in_load_address};
  assign wr_addr   = laddr_ext[AW-1:0];
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  // shared datapath pieces
  assign acc     = {1'b0, step_r} + {{(psp_pkg::STEP_W-psp_pkg::FRAC_W+1){1'b0}}, frac_r};
  assign pos_sum = {1'b0, pos_r} + {{(psp_pkg::POS_W-psp_pkg::CARRY_W+1){1'b0}}, carry_r};
  assign rd_addr = pos_sum[AW-1:0];
  assign trial   = {rem_r, nq_r[psp_pkg::NUM_W-1]};
  assign qbit    = (trial >= {1'b0, div_r});
  assign diff    = trial - {1'b0, div_r};
  assign quot    = {nq_r[psp_pkg::NUM_W-2:0], qbit};
  assign smp       = $signed({1'b0, rd_r}) - 9'sd128;
  assign prod_full = smp * $signed({1'b0, vol_r});
  assign vsum      = prod_r + 25'sd128;
  assign shifted   = vsum[psp_pkg::PROD_W-1:8];

  always_comb begin
    state_nxt    = state_r;
    playing_nxt  = playing_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    frac_nxt     = frac_r;
    step_nxt     = step_r;
    freq_nxt     = freq_r;
    rate_nxt     = rate_r;
    vol_nxt      = vol_r;
    div_nxt      = div_r;
    nq_nxt       = nq_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    carry_nxt    = carry_r;
    prod_nxt     = prod_r;
    res_byte_nxt = res_byte_r;
    res_fin_nxt  = res_fin_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt = out_byte_r;
    out_fin_nxt  = out_fin_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    start_div    = 1'b0;
    freq_sel     = freq_r;

    if (cfg_we) begin
      unique case (cfg_index)
        psp_pkg::REG_OUTPUT_RATE: rate_nxt = cfg_wdata;
        psp_pkg::REG_VOLUME:      vol_nxt  = cfg_wdata[psp_pkg::VOL_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_operation)
            psp_pkg::OP_LOAD: begin
              mem_we = 1'b1;
            end
            psp_pkg::OP_START: begin
              count_nxt   = in_length;
              freq_sel    = (in_sample_freq != '0) ? in_sample_freq : freq_r;
              freq_nxt    = freq_sel;
              pos_nxt     = '0;
              playing_nxt = 1'b1;
              start_div   = 1'b1;
            end
            psp_pkg::OP_SETFREQ: begin
              freq_sel  = in_sample_freq;
              freq_nxt  = freq_sel;
              start_div = 1'b1;
            end
            psp_pkg::OP_TICK: begin
              if (playing_r) begin
                frac_nxt  = acc[psp_pkg::FRAC_W-1:0];
                carry_nxt = acc[psp_pkg::STEP_W:psp_pkg::FRAC_W];
                if (acc[psp_pkg::STEP_W:psp_pkg::FRAC_W] != '0) begin
                  state_nxt = S_POS;
                end
              end
            end
            default: ;
          endcase
        end
        if (start_div) begin
          if (rate_r == '0) begin
            step_nxt = '0;
          end else begin
            nq_nxt  = {1'b0, freq_sel, {psp_pkg::FRAC_W{1'b0}}}
                      + {{(psp_pkg::NUM_W-psp_pkg::RATE_W+1){1'b0}},
                         rate_r[psp_pkg::RATE_W-1:1]};
            rem_nxt = '0;
            div_nxt = rate_r;
            cnt_nxt = psp_pkg::DCNT_W'(psp_pkg::DIV_STEPS - 1);
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        // one restoring quotient bit a cycle
        rem_nxt = qbit ? diff[psp_pkg::RATE_W-1:0] : trial[psp_pkg::RATE_W-1:0];
        nq_nxt  = quot;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          step_nxt  = (quot[psp_pkg::NUM_W-1:psp_pkg::STEP_W] != '0) ? '1
                      : quot[psp_pkg::STEP_W-1:0];
          state_nxt = S_IDLE;
        end
      end
      S_POS: begin
        if (pos_sum >= {{(psp_pkg::POS_W-psp_pkg::LEN_W+1){1'b0}}, count_r}) begin
          pos_nxt      = pos_sum[psp_pkg::POS_W] ? '1 : pos_sum[psp_pkg::POS_W-1:0];
          playing_nxt  = 1'b0;
          res_byte_nxt = psp_pkg::SILENCE;
          res_fin_nxt  = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          pos_nxt   = pos_sum[psp_pkg::POS_W-1:0];
          mem_re    = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = prod_full[psp_pkg::PROD_W-1:0];
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        res_fin_nxt = 1'b0;
        if (vol_r == psp_pkg::VOL_UNITY) begin
          res_byte_nxt = rd_r;
        end else if (shifted < -17'sd128) begin
          res_byte_nxt = 8'h00;
        end else if (shifted > 17'sd127) begin
          res_byte_nxt = 8'hFF;
        end else begin
          res_byte_nxt = {~shifted[7], shifted[6:0]};
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = res_byte_r;
          out_fin_nxt   = res_fin_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      playing_r   <= 1'b0;
      count_r     <= '0;
      pos_r       <= '0;
      frac_r      <= '0;
      step_r      <= '0;
      freq_r      <= psp_pkg::FREQ_RST;
      rate_r      <= psp_pkg::RATE_RST;
      vol_r       <= psp_pkg::VOL_UNITY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      playing_r   <= playing_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      frac_r      <= frac_nxt;
      step_r      <= step_nxt;
      freq_r      <= freq_nxt;
      rate_r      <= rate_nxt;
      vol_r       <= vol_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r      <= div_nxt;
    nq_r       <= nq_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    carry_r    <= carry_nxt;
    prod_r     <= prod_nxt;
    res_byte_r <= res_byte_nxt;
    res_fin_r  <= res_fin_nxt;
    out_byte_r <= out_byte_nxt;
    out_fin_r  <= out_fin_nxt;
  end

  // sample store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[wr_addr] <= in_load_byte;
    end
    if (mem_re) begin
      rd_r <= store_mem[rd_addr];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dac_byte = out_byte_r;
  assign out_finished = out_fin_r;

endmodule

>>> design/psp_checker.sv
// ----------------------------------------------------------------------------
// psp_checker
// port-level checks of the pcm sample player, bound to the top level
// ----------------------------------------------------------------------------
`include "pcm_sample_player_dac_macros.svh"

module psp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [psp_pkg::OP_W-1:0]    in_operation,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [psp_pkg::BYTE_W-1:0]  out_dac_byte,
  input logic                        out_finished
);

  // end of playback always carries the silence byte
  `PSP_ASSERT_NOW(a_finish_silence, out_valid && out_finished, out_dac_byte == psp_pkg::SILENCE)

  // a stalled result holds
  `PSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_dac_byte) && $stable(out_finished))

  // only a tick transfer can raise a result
  `PSP_ASSERT_NEXT(a_no_spurious, in_valid && !in_stall && in_operation != psp_pkg::OP_TICK && !out_valid, !out_valid)

endmodule

bind pcm_sample_player_dac psp_checker u_psp_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcm sample player testbench
// drives load, start, set-frequency and tick transfers with random gaps and
// output stalls, predicts every dac byte with a 16.16 phase accumulator model
// and compares each result transfer field by field, in order
// ----------------------------------------------------------------------------
import psp_pkg::*;

typedef struct packed {
  logic [OP_W-1:0]    op;
  logic [LADDR_W-1:0] addr;
  logic [BYTE_W-1:0]  data;
  logic [LEN_W-1:0]   len;
  logic [FREQ_W-1:0]  freq;
} pcm_item_t;

typedef struct packed {
  logic [BYTE_W-1:0] dac;
  logic              fin;
} dac_out_t;

class playback_model;
  logic [BYTE_W-1:0] store [STORE_DEPTH_DEF];
  bit                written [STORE_DEPTH_DEF];
  bit                playing;
  logic [LEN_W-1:0]  count;
  logic [POS_W-1:0]  pos;
  logic [FRAC_W-1:0] frac;
  logic [STEP_W-1:0] step;
  logic [FREQ_W-1:0] freq;
  logic [RATE_W-1:0] rate;
  logic [VOL_W-1:0]  vol;
  dac_out_t          dac_queue[$];
  int                errors;

  function new();
    playing = 1'b0;
    count   = '0;
    pos     = '0;
    frac    = '0;
    step    = '0;
    freq    = FREQ_RST;
    rate    = RATE_RST;
    vol     = VOL_UNITY;
    errors  = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    if (idx == REG_OUTPUT_RATE) begin
      rate = d[RATE_W-1:0];
    end else if (idx == REG_VOLUME) begin
      vol = d[VOL_W-1:0];
    end
  endfunction

  function logic [STEP_W-1:0] step_for_freq();
    logic [63:0] q;
    if (rate == '0) return '0;
    q = {44'd0, freq};
    q = (q << FRAC_W) + {46'd0, rate >> 1};
    q = q / {46'd0, rate};
    if (q > 64'hFFFF_FFFF) return '1;
    return q[STEP_W-1:0];
  endfunction

  function logic [BYTE_W-1:0] scaled(logic [BYTE_W-1:0] raw);
    longint r;
    longint g;
    longint v;
    if (vol == VOL_UNITY) return raw;
    r = raw;
    g = vol;
    v = (r - 128) * g + 128;
    v = v >>> 8;
    if (v < -128) v = -128;
    else if (v > 127) v = 127;
    v = v + 128;
    return v[BYTE_W-1:0];
  endfunction

  // store address a tick would read right now, if it reads at all
  function bit read_addr(output logic [LADDR_W-1:0] a);
    logic [32:0] acc;
    logic [32:0] p;
    acc = {17'd0, frac} + {1'b0, step};
    p   = {1'b0, pos} + {16'd0, acc[32:16]};
    a   = p[LADDR_W-1:0];
    return playing && (acc[32:16] != '0) && (p < {16'd0, count});
  endfunction

  function void apply_item(pcm_item_t it);
    logic [32:0] acc;
    logic [32:0] p;
    dac_out_t    r;
    case (it.op)
      OP_LOAD: begin
        store[it.addr]   = it.data;
        written[it.addr] = 1'b1;
      end
      OP_START: begin
        count = it.len;
        if (it.freq != '0) freq = it.freq;
        step    = step_for_freq();
        pos     = '0;
        playing = 1'b1;
      end
      OP_SETFREQ: begin
        freq = it.freq;
        step = step_for_freq();
      end
      default: begin
        if (playing) begin
          acc  = {17'd0, frac} + {1'b0, step};
          frac = acc[FRAC_W-1:0];
          if (acc[32:16] != '0) begin
            p = {1'b0, pos} + {16'd0, acc[32:16]};
            if (p >= {16'd0, count}) begin
              pos     = p[32] ? '1 : p[31:0];
              playing = 1'b0;
              r.dac   = SILENCE;
              r.fin   = 1'b1;
            end else begin
              pos   = p[31:0];
              r.dac = scaled(store[pos[LADDR_W-1:0]]);
              r.fin = 1'b0;
            end
            dac_queue.push_back(r);
          end
        end
      end
    endcase
  endfunction

  function void check_dac(logic [BYTE_W-1:0] dac, logic fin);
    dac_out_t e;
    if (dac_queue.size() == 0) begin
      $error("unexpected dac transfer: dac_byte %02h finished %0b", dac, fin);
      errors++;
      return;
    end
    e = dac_queue.pop_front();
    if (dac !== e.dac) begin
      $error("dac_byte expected %02h actual %02h", e.dac, dac);
      errors++;
    end
    if (fin !== e.fin) begin
      $error("finished expected %0b actual %0b", e.fin, fin);
      errors++;
    end
  endfunction

  function int pending();
    return dac_queue.size();
  endfunction
endclass

module tb;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [OP_W-1:0]       in_operation;
  logic [LADDR_W-1:0]    in_load_address;
  logic [BYTE_W-1:0]     in_load_byte;
  logic [LEN_W-1:0]      in_length;
  logic [FREQ_W-1:0]     in_sample_freq;
  logic                  out_valid;
  logic                  out_stall;
  logic [BYTE_W-1:0]     out_dac_byte;
  logic                  out_finished;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  playback_model sb = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int item_count    = 0;
  int hold_cycles;
  bit hold_req      = 1'b0;

  pcm_sample_player_dac u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_load_address (in_load_address),
    .in_load_byte    (in_load_byte),
    .in_length       (in_length),
    .in_sample_freq  (in_sample_freq),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dac_byte    (out_dac_byte),
    .out_finished    (out_finished),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_stall   = 1'b0;
    hold_cycles = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_cycles = 400;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_dac(out_dac_byte, out_finished);
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic pcm_item_t any_item();
    pcm_item_t it;
    it.op   = OP_W'($urandom_range(3));
    it.addr = LADDR_W'($urandom);
    it.data = BYTE_W'($urandom);
    it.len  = LEN_W'($urandom_range(65536));
    it.freq = FREQ_W'($urandom);
    return it;
  endfunction

  function automatic logic [FREQ_W-1:0] pick_freq();
    longint f;
    if ($urandom_range(9) == 0) return '0;
    if (sb.rate == '0) return FREQ_W'($urandom_range(1, 1048575));
    f = sb.rate;
    f = f * $urandom_range(1, 32) / 8;
    if (f > 1048575) f = 1048575;
    if (f == 0) f = 1;
    return f[FREQ_W-1:0];
  endfunction

  task automatic push(pcm_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= it.op;
    in_load_address <= it.addr;
    in_load_byte    <= it.data;
    in_length       <= it.len;
    in_sample_freq  <= it.freq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.op != OP_TICK || sb.playing) item_count++;
    sb.apply_item(it);
  endtask

  // a tick about to read a store entry never written gets a load first
  task automatic send(pcm_item_t it);
    pcm_item_t          fill;
    logic [LADDR_W-1:0] a;
    if (it.op == OP_TICK && sb.read_addr(a)) begin
      if (!sb.written[a]) begin
        fill      = any_item();
        fill.op   = OP_LOAD;
        fill.addr = a;
        push(fill);
      end
    end
    push(it);
  endtask

  task automatic op_load(input logic [LADDR_W-1:0] a, input logic [BYTE_W-1:0] d);
    pcm_item_t it;
    it      = any_item();
    it.op   = OP_LOAD;
    it.addr = a;
    it.data = d;
    send(it);
  endtask

  task automatic op_start(input logic [LEN_W-1:0] n, input logic [FREQ_W-1:0] f);
    pcm_item_t it;
    it      = any_item();
    it.op   = OP_START;
    it.len  = n;
    it.freq = f;
    send(it);
  endtask

  task automatic op_setfreq(input logic [FREQ_W-1:0] f);
    pcm_item_t it;
    it      = any_item();
    it.op   = OP_SETFREQ;
    it.freq = f;
    send(it);
  endtask

  task automatic op_tick();
    pcm_item_t it;
    it    = any_item();
    it.op = OP_TICK;
    send(it);
  endtask

  // drain all results, then let a division in work run out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic session();
    int len;
    int r;
    int ticks;
    r = $urandom_range(99);
    if (r < 6) len = 0;
    else if (r < 10) len = 65536;
    else if (r < 14) len = $urandom_range(65536);
    else len = $urandom_range(1, 24);
    repeat ($urandom_range(6)) op_load(LADDR_W'($urandom_range(len)), BYTE_W'($urandom));
    op_start(LEN_W'(len), pick_freq());
    ticks = 0;
    while (sb.playing && ticks < 64) begin
      if ($urandom_range(99) < 3) op_setfreq(pick_freq());
      else op_tick();
      ticks++;
    end
  endtask

  initial begin : main
    logic [CFG_DATA_W-1:0] rate_sel [4];
    logic [CFG_DATA_W-1:0] vol_sel [4];
    int                    pct_send [4];
    int                    pct_stall [4];
    int                    target;
    int                    mid;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_LOAD;
    in_load_address = '0;
    in_load_byte    = '0;
    in_length       = '0;
    in_sample_freq  = '0;
    cfg_we          = 1'b0;
    cfg_index       = REG_OUTPUT_RATE;
    cfg_wdata       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    op_tick();
    op_load(16'h0000, 8'h00);
    op_load(16'hFFFF, 8'hFF);
    op_load(16'h0001, 8'hFF);
    op_load(16'h0002, 8'h00);
    op_load(16'h0003, 8'h80);
    op_start(17'd0, 20'd0);
    repeat (3) op_tick();
    op_start(17'd4, 20'd44100);
    repeat (4) op_tick();
    op_start(17'd4, 20'd0);
    op_setfreq(20'd0);
    repeat (2) op_tick();
    settle();
    write_reg(REG_OUTPUT_RATE, 18'd1);
    write_reg(REG_VOLUME, 18'd0);
    op_start(17'd65536, 20'hFFFFF);
    repeat (2) op_tick();
    settle();
    write_reg(REG_OUTPUT_RATE, 18'd0);
    op_start(17'd1, 20'd1000);
    op_tick();

    // long receiver hold-off while ticks keep coming
    settle();
    write_reg(REG_OUTPUT_RATE, CFG_DATA_W'(RATE_RST));
    write_reg(REG_VOLUME, 18'd200);
    op_start(17'd48, 20'd44100);
    hold_req = 1'b1;
    repeat (40) op_tick();

    rate_sel  = '{18'd44100, 18'd1, 18'd192000, 18'd0};
    vol_sel   = '{18'h100, 18'd0, 18'hFFFF, 18'd0};
    pct_send  = '{0, 69, 0, 34};
    pct_stall = '{0, 0, 69, 34};
    rate_sel[3] = CFG_DATA_W'($urandom_range(1, 192000));
    vol_sel[3]  = CFG_DATA_W'($urandom_range(65535));

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      send_idle_pct = pct_send[ph];
      stall_pct     = pct_stall[ph];
      write_reg(REG_OUTPUT_RATE, rate_sel[ph]);
      write_reg(REG_VOLUME, vol_sel[ph]);
      target = item_count + 75;
      mid    = item_count + 37;
      while (item_count < target) begin
        if (mid != 0 && item_count >= mid) begin
          mid = 0;
          settle();
          write_reg(REG_OUTPUT_RATE, CFG_DATA_W'($urandom_range(1, 192000)));
          if ($urandom_range(1) == 0) write_reg(REG_VOLUME, 18'h100);
          else write_reg(REG_VOLUME, CFG_DATA_W'($urandom_range(65535)));
        end
        if ($urandom_range(99) < 80) session();
        else send(any_item());
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
